>>> hw/rtl/pidc_pkg.sv
// Shared types, constants and the control program for the clamped PID block.
// Used by pidc_regs, pidc_useq, pidc_dpath and pid_controller_clamped.
// No dependencies.
`default_nettype none

package pidc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_OUTPUT_LIMIT   = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4,
    CFG_STEP_TIME      = 3'd5,
    CFG_STEP_RATE      = 3'd6
  } cfg_idx_e;

  // Input opcodes.
  typedef enum logic {
    OP_RUN   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StepW    = 4;

  // Reset values: 1.5, 0.5, 1.0, 30.0, 30.0 (Q8.8), 1/16 s, 16 Hz.
  localparam logic [15:0] RST_GAIN_P         = 16'd384;
  localparam logic [15:0] RST_GAIN_I         = 16'd128;
  localparam logic [15:0] RST_GAIN_D         = 16'd256;
  localparam logic [14:0] RST_OUTPUT_LIMIT   = 15'd7680;
  localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd7680;
  localparam logic [15:0] RST_STEP_TIME      = 16'd4096;
  localparam logic [10:0] RST_STEP_RATE      = 11'd16;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] output_limit;
    logic [14:0] integral_limit;
    logic [15:0] step_time;
    logic [10:0] step_rate;
  } cfg_t;

  // Multiplier operand selects.
  typedef enum logic [1:0] {
    A_X    = 2'd0,
    A_INTG = 2'd1,
    A_DIFF = 2'd2,
    A_PROD = 2'd3
  } a_sel_e;

  typedef enum logic [2:0] {
    B_STEP_TIME = 3'd0,
    B_GAIN_P    = 3'd1,
    B_GAIN_I    = 3'd2,
    B_GAIN_D    = 3'd3,
    B_STEP_RATE = 3'd4
  } b_sel_e;

  // Accumulator operations.
  typedef enum logic [1:0] {
    ACC_NONE   = 2'd0,
    ACC_LOAD16 = 2'd1,
    ACC_ADD    = 2'd2,
    ACC_ADD16  = 2'd3
  } acc_op_e;

  // One control word of the program.
  typedef struct packed {
    logic             mul_en;
    a_sel_e           a_sel;
    b_sel_e           b_sel;
    logic             int_upd;
    logic             int_clr;
    acc_op_e          acc_op;
    logic             prev_wr;
    logic             rnd;
    logic             emit;
    logic             emit_zero;
    logic             jmp_clr;
    logic [StepW-1:0] jmp_addr;
    logic             last;
  } ucw_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic load;
    logic fire;
    ucw_t cw;
  } ctl_t;

  // Program step addresses.
  localparam logic [StepW-1:0] ST_MUL_XT  = 4'd0;
  localparam logic [StepW-1:0] ST_INTEG   = 4'd1;
  localparam logic [StepW-1:0] ST_LOAD_P  = 4'd2;
  localparam logic [StepW-1:0] ST_ADD_I   = 4'd3;
  localparam logic [StepW-1:0] ST_MUL_SR  = 4'd4;
  localparam logic [StepW-1:0] ST_ADD_D   = 4'd5;
  localparam logic [StepW-1:0] ST_ROUND   = 4'd6;
  localparam logic [StepW-1:0] ST_EMIT    = 4'd7;
  localparam logic [StepW-1:0] ST_CLEAR   = 4'd8;
  localparam logic [StepW-1:0] ST_MAX     = 4'd8;

  // The control program. The multiplier result of each multiplying step is used by the next.
  function automatic ucw_t ucode(input logic [StepW-1:0] step);
    ucw_t w;
    w = '{mul_en: 1'b0, a_sel: A_X, b_sel: B_STEP_TIME, int_upd: 1'b0,
          int_clr: 1'b0, acc_op: ACC_NONE, prev_wr: 1'b0, rnd: 1'b0,
          emit: 1'b0, emit_zero: 1'b0, jmp_clr: 1'b0, jmp_addr: ST_CLEAR,
          last: 1'b0};
    case (step)
      ST_MUL_XT: begin
        w.mul_en  = 1'b1;
        w.a_sel   = A_X;
        w.b_sel   = B_STEP_TIME;
        w.jmp_clr = 1'b1;
      end
      ST_INTEG: begin
        w.int_upd = 1'b1;
        w.mul_en  = 1'b1;
        w.a_sel   = A_X;
        w.b_sel   = B_GAIN_P;
      end
      ST_LOAD_P: begin
        w.acc_op = ACC_LOAD16;
        w.mul_en = 1'b1;
        w.a_sel  = A_INTG;
        w.b_sel  = B_GAIN_I;
      end
      ST_ADD_I: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1;
        w.a_sel  = A_DIFF;
        w.b_sel  = B_GAIN_D;
      end
      ST_MUL_SR: begin
        w.mul_en = 1'b1;
        w.a_sel  = A_PROD;
        w.b_sel  = B_STEP_RATE;
      end
      ST_ADD_D: begin
        w.acc_op  = ACC_ADD16;
        w.prev_wr = 1'b1;
      end
      ST_ROUND: begin
        w.rnd = 1'b1;
      end
      ST_EMIT: begin
        w.emit = 1'b1;
        w.last = 1'b1;
      end
      ST_CLEAR: begin
        w.int_clr   = 1'b1;
        w.emit      = 1'b1;
        w.emit_zero = 1'b1;
        w.last      = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pidc_regs.sv
// Configuration register file of the clamped PID block.
// Depends on pidc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module pidc_regs
  import pidc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  wire logic [2:0]          index_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output      cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (cfg_idx_e'(index_i))
        CFG_GAIN_P:         cfg_d.gain_p         = data_i;
        CFG_GAIN_I:         cfg_d.gain_i         = data_i;
        CFG_GAIN_D:         cfg_d.gain_d         = data_i;
        CFG_OUTPUT_LIMIT:   cfg_d.output_limit   = data_i[14:0];
        CFG_INTEGRAL_LIMIT: cfg_d.integral_limit = data_i[14:0];
        CFG_STEP_TIME:      cfg_d.step_time      = data_i;
        CFG_STEP_RATE:      cfg_d.step_rate      = data_i[10:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_p: RST_GAIN_P, gain_i: RST_GAIN_I, gain_d: RST_GAIN_D,
                 output_limit: RST_OUTPUT_LIMIT, integral_limit: RST_INTEGRAL_LIMIT,
                 step_time: RST_STEP_TIME, step_rate: RST_STEP_RATE};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/pidc_useq.sv
// Microcode sequencer: step counter, program lookup and the clear-command jump.
// Depends on pidc_pkg for the control word, the program and ctl_t.
`default_nettype none

module pidc_useq
  import pidc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire logic opcode_i,
  input  wire logic out_valid_i,
  input  wire logic out_ready_i,
  output      ctl_t ctl_o
);

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic             op_q, op_d;
  logic             start;
  logic             stall;
  ucw_t             cw;

  assign in_ready_o = !busy_q;
  assign start      = in_valid_i && in_ready_o;
  assign cw         = ucode(step_q);
  // The emitting step waits while the output register still holds an untaken beat.
  assign stall      = cw.emit && out_valid_i && !out_ready_i;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    op_d   = op_q;
    if (start) begin
      busy_d = 1'b1;
      step_d = ST_MUL_XT;
      op_d   = opcode_i;
    end else if (busy_q && !stall) begin
      if (cw.last) begin
        busy_d = 1'b0;
      end else if (cw.jmp_clr && (op_e'(op_q) == OP_CLEAR)) begin
        step_d = cw.jmp_addr;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_MUL_XT;
      op_q   <= OP_RUN;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      op_q   <= op_d;
    end
  end

  assign ctl_o.load = start;
  assign ctl_o.fire = busy_q && !stall;
  assign ctl_o.cw   = cw;

`ifndef SYNTHESIS
  a_start_enters_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy_q && (step_q == ST_MUL_XT))
    else $error("sequencer did not enter the first step after a beat");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= ST_MAX)
    else $error("step counter left the program");

  a_finish_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cw.last) && $past(ctl_o.fire))
    else $error("sequencer went idle before a last step");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/pidc_dpath.sv
// Datapath: shared 34x17 multiplier, integral with clamp, accumulator,
// rounding, output clamp and output register. Depends on pidc_pkg.
`default_nettype none

module pidc_dpath
  import pidc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctl_t        ctl_i,
  input  wire cfg_t        cfg_i,
  input  wire logic [15:0] position_x_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] drive_shift_o,
  output      logic        output_clamped_o
);

  localparam logic signed [63:0] RndHalf = 64'sd8388608;

  logic signed [15:0] x_q, prev_q;
  logic signed [31:0] int_q;
  logic signed [50:0] p_q;
  logic signed [63:0] acc_q;
  logic signed [39:0] drv_q;
  logic               out_valid_q;
  logic [15:0]        drive_q;
  logic               clamp_q;

  logic signed [16:0] diff;
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] prod;
  logic signed [33:0] int_sum, int_lim, int_new;
  logic signed [63:0] p_ext, acc_new, rnd_sum;
  logic signed [39:0] lim40;
  logic [15:0]        drive_new;
  logic               clamp_new;

  assign diff = 17'(x_q) - 17'(prev_q);

  always_comb begin
    case (ctl_i.cw.a_sel)
      A_X:     mul_a = 34'(x_q);
      A_INTG:  mul_a = 34'(int_q);
      A_DIFF:  mul_a = 34'(diff);
      A_PROD:  mul_a = $signed(p_q[33:0]);
      default: mul_a = 34'(x_q);
    endcase
    case (ctl_i.cw.b_sel)
      B_STEP_TIME: mul_b = $signed({1'b0, cfg_i.step_time});
      B_GAIN_P:    mul_b = $signed({1'b0, cfg_i.gain_p});
      B_GAIN_I:    mul_b = $signed({1'b0, cfg_i.gain_i});
      B_GAIN_D:    mul_b = $signed({1'b0, cfg_i.gain_d});
      B_STEP_RATE: mul_b = $signed({6'd0, cfg_i.step_rate});
      default:     mul_b = $signed({1'b0, cfg_i.step_time});
    endcase
  end

  assign prod = mul_a * mul_b;

  // The integral limit is given in Q8.8 and the integral is Q8.24.
  assign int_sum = 34'(int_q) + $signed(p_q[33:0]);
  assign int_lim = $signed({3'b000, cfg_i.integral_limit, 16'h0000});

  always_comb begin
    if (int_sum > int_lim) begin
      int_new = int_lim;
    end else if (int_sum < -int_lim) begin
      int_new = -int_lim;
    end else begin
      int_new = int_sum;
    end
  end

  assign p_ext = 64'(p_q);

  always_comb begin
    case (ctl_i.cw.acc_op)
      ACC_LOAD16: acc_new = p_ext <<< 16;
      ACC_ADD:    acc_new = acc_q + p_ext;
      ACC_ADD16:  acc_new = acc_q + (p_ext <<< 16);
      default:    acc_new = acc_q;
    endcase
  end

  // Negate and add one half LSB of Q8.8; the top 40 bits are the floor.
  assign rnd_sum = (~acc_q) + 64'sd1 + RndHalf;

  assign lim40 = $signed({25'd0, cfg_i.output_limit});

  always_comb begin
    if (ctl_i.cw.emit_zero) begin
      drive_new = 16'd0;
      clamp_new = 1'b0;
    end else if (drv_q > lim40) begin
      drive_new = lim40[15:0];
      clamp_new = 1'b1;
    end else if (drv_q < -lim40) begin
      drive_new = 16'((-lim40));
      clamp_new = 1'b1;
    end else begin
      drive_new = drv_q[15:0];
      clamp_new = 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= $signed(position_x_i);
    end
    if (ctl_i.fire) begin
      if (ctl_i.cw.mul_en) begin
        p_q <= prod;
      end
      if (ctl_i.cw.acc_op != ACC_NONE) begin
        acc_q <= acc_new;
      end
      if (ctl_i.cw.rnd) begin
        drv_q <= rnd_sum[63:24];
      end
      if (ctl_i.cw.emit) begin
        drive_q <= drive_new;
        clamp_q <= clamp_new;
      end
    end
  end

  // Controller state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.fire && ctl_i.cw.int_clr) begin
        int_q <= '0;
      end else if (ctl_i.fire && ctl_i.cw.int_upd) begin
        int_q <= int_new[31:0];
      end
      if (ctl_i.fire && ctl_i.cw.prev_wr) begin
        prev_q <= x_q;
      end
      if (ctl_i.fire && ctl_i.cw.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_shift_o    = drive_q;
  assign output_clamped_o = clamp_q;

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire && ctl_i.cw.int_clr |=> (int_q == 32'sd0) && (drive_shift_o == 16'd0)
      && !output_clamped_o && out_valid_o)
    else $error("clear beat did not zero the integral and the drive");

  a_drive_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(drive_shift_o) <= $signed({1'b0, cfg_i.output_limit}))
      && ($signed(drive_shift_o) >= -$signed({1'b0, cfg_i.output_limit})))
    else $error("drive beyond the output limit");

  a_clamp_flag_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && output_clamped_o |->
      (drive_shift_o == {1'b0, cfg_i.output_limit})
      || (drive_shift_o == 16'(-$signed({1'b0, cfg_i.output_limit}))))
    else $error("clamp flag set with the drive off the limit");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/pid_controller_clamped.sv
// Top level of the clamped PID controller: register file, sequencer, datapath.
// Depends on pidc_pkg, pidc_regs, pidc_useq and pidc_dpath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  opcode_i, position_x_i
//   out      output     out_valid_o/out_ready_i drive_shift_o, output_clamped_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A run beat takes 8 program steps after acceptance, a clear beat 2; the next
// beat is taken in the cycle after the last step; beats do not overlap.
// The single shared 34x17 multiplier makes at most one product a step.
// The result waits in an output register; only the emitting step stalls on it.
// Reset is asynchronous; the integral and the previous sample reset to zero.
// The configuration port is always ready.
`default_nettype none

module pid_controller_clamped
  import pidc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic                opcode_i,
  input  wire logic [15:0]         position_x_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [15:0]         drive_shift_o,
  output      logic                output_clamped_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;
  ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  pidc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  pidc_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  pidc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .cfg_i            (cfg),
    .position_x_i     (position_x_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_shift_o    (drive_shift_o),
    .output_clamped_o (output_clamped_o)
  );

endmodule

`default_nettype wire
